### sv/tieq_pkg.sv
`default_nettype none

package tieq_pkg;

    // Sizing
    localparam int DEFAULT_DEPTH = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int RES_W         = $clog2(MAX_RESULTS + 1);

    // Item modes
    localparam logic [3:0] MODE_PUSH   = 4'd0;
    localparam logic [3:0] MODE_KEY    = 4'd1;
    localparam logic [3:0] MODE_BUTTON = 4'd2;
    localparam logic [3:0] MODE_DELTA  = 4'd3;
    localparam logic [3:0] MODE_POS    = 4'd4;
    localparam logic [3:0] MODE_PEEK   = 4'd5;
    localparam logic [3:0] MODE_POP    = 4'd6;
    localparam logic [3:0] MODE_CLEAR  = 4'd7;
    localparam logic [3:0] MODE_LIST   = 4'd8;

    // Event kinds
    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_BUTTON = 2'd1;
    localparam logic [1:0] KIND_DELTA  = 2'd2;
    localparam logic [1:0] KIND_POS    = 2'd3;

    // Commands broadcast along the cell row
    localparam logic [2:0] CELL_HOLD   = 3'd0;
    localparam logic [2:0] CELL_INSERT = 3'd1;
    localparam logic [2:0] CELL_REMOVE = 3'd2;
    localparam logic [2:0] CELL_ADD    = 3'd3;
    localparam logic [2:0] CELL_SET    = 3'd4;

    typedef struct packed {
        logic [31:0]        time_v;
        logic [1:0]         kind;
        logic [7:0]         key;
        logic               down;
        logic signed [15:0] h;
        logic signed [15:0] v;
    } entry_t;

    typedef struct packed {
        logic [2:0] op;
        entry_t     ent;
    } cell_cmd_t;

    typedef struct packed {
        logic due;
        logic future_key;
    } cell_flags_t;

endpackage

`default_nettype wire

### sv/tieq_cell.sv
`default_nettype none

module tieq_cell #(
    parameter int AW         = 4,
    parameter int CELL_INDEX = 0
) (
    input  wire                   aclk,
    input  wire tieq_pkg::cell_cmd_t cmd,
    input  wire [AW-1:0]          pos,
    input  wire [31:0]            now,
    input  wire tieq_pkg::entry_t left_q,
    input  wire tieq_pkg::entry_t right_q,
    output tieq_pkg::entry_t      q,
    output tieq_pkg::cell_flags_t flags
);

    localparam logic [AW-1:0] MY_IDX = AW'(CELL_INDEX);

    tieq_pkg::entry_t ent_reg;
    tieq_pkg::entry_t ent_next;

    // Shift, insert or update this slot
    always_comb begin
        ent_next = ent_reg;
        case (cmd.op)
            tieq_pkg::CELL_INSERT: begin
                if (MY_IDX == pos) begin
                    ent_next = cmd.ent;
                end else if (MY_IDX > pos) begin
                    ent_next = left_q;
                end
            end
            tieq_pkg::CELL_REMOVE: begin
                if (MY_IDX >= pos) begin
                    ent_next = right_q;
                end
            end
            tieq_pkg::CELL_ADD: begin
                if (MY_IDX == pos) begin
                    ent_next.h = ent_reg.h + cmd.ent.h;
                    ent_next.v = ent_reg.v + cmd.ent.v;
                end
            end
            tieq_pkg::CELL_SET: begin
                if (MY_IDX == pos) begin
                    ent_next.h = cmd.ent.h;
                    ent_next.v = cmd.ent.v;
                end
            end
            default: begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    // Local status against the current time
    assign q                = ent_reg;
    assign flags.due        = (ent_reg.time_v <= now);
    assign flags.future_key = (ent_reg.time_v > now) && (ent_reg.kind == tieq_pkg::KIND_KEY);

endmodule

`default_nettype wire

### sv/timed_input_event_queue.sv
// Timed input event queue. Events live in a row of QUEUE_DEPTH cells; due events sit at the
// front in arrival order, future events behind them sorted by fire time. One item is handled
// at a time. Pushes scan the row one cell per cycle from the front (due events) or the back
// (future events). Clearing future keys walks the row once, pulling the tail left for each
// removed key. Listing future keys walks the row twice (count, then emit), and each listed
// event also waits for the output register to be free. The next item may be accepted while
// the last result beat of the previous one is still held in the output register.
`default_nettype none

module timed_input_event_queue #(
    parameter int QUEUE_DEPTH = tieq_pkg::DEFAULT_DEPTH
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire  [3:0]         s_mode,
    input  wire  [31:0]        s_now,
    input  wire  [31:0]        s_fire_time,
    input  wire  [1:0]         s_kind,
    input  wire  [7:0]         s_key,
    input  wire                s_down,
    input  wire  signed [15:0] s_pos_h,
    input  wire  signed [15:0] s_pos_v,
    output logic               m_valid,
    input  wire                m_ready,
    output logic               m_hit,
    output logic [1:0]         m_ev_kind,
    output logic [31:0]        m_ev_time,
    output logic [7:0]         m_ev_key,
    output logic               m_ev_down,
    output logic signed [15:0] m_ev_h,
    output logic signed [15:0] m_ev_v,
    output logic [4:0]         m_queue_count,
    output logic               m_rejected,
    output logic               m_last_item
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = tieq_pkg::RES_W;
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FWD    = 4'd1;
    localparam logic [3:0] ST_BACK   = 4'd2;
    localparam logic [3:0] ST_PEEK   = 4'd3;
    localparam logic [3:0] ST_POP    = 4'd4;
    localparam logic [3:0] ST_CLEAR  = 4'd5;
    localparam logic [3:0] ST_COUNT  = 4'd6;
    localparam logic [3:0] ST_LIST   = 4'd7;
    localparam logic [3:0] ST_RESULT = 4'd8;

    // Control state
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] fidx_reg, fidx_next;
    logic          found_reg, found_next;
    logic          rej_reg, rej_next;
    logic [RW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] sent_reg, sent_next;

    // Latched item
    logic [3:0]       mode_reg;
    logic [31:0]      now_reg;
    tieq_pkg::entry_t new_reg;
    tieq_pkg::entry_t new_in;

    // Output register
    logic             m_valid_reg, m_valid_next;
    logic             out_hit_reg, out_rej_reg, out_last_reg;
    logic [4:0]       out_count_reg;
    tieq_pkg::entry_t out_ent_reg;

    // Load strobe and data for the output register
    logic             load;
    logic             ld_hit, ld_rej, ld_last;
    tieq_pkg::entry_t ld_ent;
    logic             out_free;

    // Cell row
    tieq_pkg::cell_cmd_t   cmd;
    logic [AW-1:0]         cmd_pos;
    tieq_pkg::entry_t      cells_q [QUEUE_DEPTH];
    tieq_pkg::cell_flags_t cells_f [QUEUE_DEPTH];
    logic [AW-1:0]         rd_addr;
    tieq_pkg::entry_t      cur;
    tieq_pkg::cell_flags_t cur_f;
    logic                  coal;
    logic [1:0]            tgt_kind;
    logic                  in_range;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            tieq_pkg::entry_t lq;
            tieq_pkg::entry_t rq;
            if (gi == 0) begin : g_first
                assign lq = cmd.ent;
            end else begin : g_mid_l
                assign lq = cells_q[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign rq = cells_q[gi];
            end else begin : g_mid_r
                assign rq = cells_q[gi+1];
            end
            tieq_cell #(
                .AW         (AW),
                .CELL_INDEX (gi)
            ) u_cell (
                .aclk    (aclk),
                .cmd     (cmd),
                .pos     (cmd_pos),
                .now     (now_reg),
                .left_q  (lq),
                .right_q (rq),
                .q       (cells_q[gi]),
                .flags   (cells_f[gi])
            );
        end
    endgenerate

    // New event built from the incoming beat
    always_comb begin
        new_in = '0;
        case (s_mode)
            tieq_pkg::MODE_PUSH: begin
                new_in.time_v = s_fire_time;
                new_in.kind   = s_kind;
                new_in.key    = s_key;
                new_in.down   = s_down;
                new_in.h      = s_pos_h;
                new_in.v      = s_pos_v;
            end
            tieq_pkg::MODE_KEY: begin
                new_in.time_v = s_now;
                new_in.kind   = tieq_pkg::KIND_KEY;
                new_in.key    = s_key;
                new_in.down   = s_down;
            end
            tieq_pkg::MODE_BUTTON: begin
                new_in.time_v = s_now;
                new_in.kind   = tieq_pkg::KIND_BUTTON;
                new_in.down   = s_down;
            end
            tieq_pkg::MODE_DELTA: begin
                new_in.time_v = s_now;
                new_in.kind   = tieq_pkg::KIND_DELTA;
                new_in.h      = s_pos_h;
                new_in.v      = s_pos_v;
            end
            tieq_pkg::MODE_POS: begin
                new_in.time_v = s_now;
                new_in.kind   = tieq_pkg::KIND_POS;
                new_in.h      = s_pos_h;
                new_in.v      = s_pos_v;
            end
            default: begin
                new_in = '0;
            end
        endcase
    end

    // Scan read port: one cell a cycle
    assign rd_addr  = (state_reg == ST_BACK) ? AW'(idx_reg - 1'b1) : idx_reg[AW-1:0];
    assign cur      = cells_q[rd_addr];
    assign cur_f    = cells_f[rd_addr];
    assign in_range = (idx_reg < fill_reg);

    assign coal     = (mode_reg == tieq_pkg::MODE_DELTA) || (mode_reg == tieq_pkg::MODE_POS);
    assign tgt_kind = (mode_reg == tieq_pkg::MODE_DELTA) ? tieq_pkg::KIND_DELTA
                                                         : tieq_pkg::KIND_POS;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        fidx_next  = fidx_reg;
        found_next = found_reg;
        rej_next   = rej_reg;
        cnt_next   = cnt_reg;
        sent_next  = sent_reg;
        cmd.op     = tieq_pkg::CELL_HOLD;
        cmd.ent    = new_reg;
        cmd_pos    = idx_reg[AW-1:0];
        load       = 1'b0;
        ld_hit     = 1'b0;
        ld_rej     = 1'b0;
        ld_last    = 1'b1;
        ld_ent     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    rej_next   = 1'b0;
                    cnt_next   = '0;
                    sent_next  = '0;
                    case (s_mode)
                        tieq_pkg::MODE_PUSH: begin
                            if (fill_reg == FULL) begin
                                rej_next   = 1'b1;
                                state_next = ST_RESULT;
                            end else if (s_fire_time <= s_now) begin
                                state_next = ST_FWD;
                            end else begin
                                idx_next   = fill_reg;
                                state_next = ST_BACK;
                            end
                        end
                        tieq_pkg::MODE_KEY, tieq_pkg::MODE_BUTTON: begin
                            if (fill_reg == FULL) begin
                                rej_next   = 1'b1;
                                state_next = ST_RESULT;
                            end else begin
                                state_next = ST_FWD;
                            end
                        end
                        tieq_pkg::MODE_DELTA, tieq_pkg::MODE_POS: state_next = ST_FWD;
                        tieq_pkg::MODE_PEEK:  state_next = ST_PEEK;
                        tieq_pkg::MODE_POP:   state_next = ST_POP;
                        tieq_pkg::MODE_CLEAR: state_next = ST_CLEAR;
                        tieq_pkg::MODE_LIST:  state_next = ST_COUNT;
                        default:              state_next = ST_RESULT;
                    endcase
                end
            end

            // Walk the due prefix; coalesce or insert where it ends
            ST_FWD: begin
                if (in_range && cur_f.due) begin
                    if (coal && (cur.kind == tgt_kind)) begin
                        found_next = 1'b1;
                        fidx_next  = idx_reg[AW-1:0];
                    end
                    idx_next = CW'(idx_reg + 1'b1);
                end else begin
                    state_next = ST_RESULT;
                    if (found_reg) begin
                        cmd.op  = (mode_reg == tieq_pkg::MODE_DELTA) ? tieq_pkg::CELL_ADD
                                                                     : tieq_pkg::CELL_SET;
                        cmd_pos = fidx_reg;
                    end else if (fill_reg == FULL) begin
                        rej_next = 1'b1;
                    end else begin
                        cmd.op    = tieq_pkg::CELL_INSERT;
                        fill_next = CW'(fill_reg + 1'b1);
                    end
                end
            end

            // Walk back from the tail past later fire times
            ST_BACK: begin
                if ((idx_reg != '0) && (cur.time_v > new_reg.time_v)) begin
                    idx_next = CW'(idx_reg - 1'b1);
                end else begin
                    cmd.op     = tieq_pkg::CELL_INSERT;
                    fill_next  = CW'(fill_reg + 1'b1);
                    state_next = ST_RESULT;
                end
            end

            ST_PEEK: begin
                if (out_free) begin
                    load       = 1'b1;
                    ld_hit     = (fill_reg != '0) && cells_f[0].due;
                    ld_ent     = ld_hit ? cells_q[0] : '0;
                    state_next = ST_IDLE;
                end
            end

            ST_POP: begin
                if (fill_reg != '0) begin
                    cmd.op    = tieq_pkg::CELL_REMOVE;
                    cmd_pos   = '0;
                    fill_next = CW'(fill_reg - 1'b1);
                end
                state_next = ST_RESULT;
            end

            // Drop future keys; the tail closes up one slot per removal
            ST_CLEAR: begin
                if (in_range) begin
                    if (cur_f.future_key) begin
                        cmd.op    = tieq_pkg::CELL_REMOVE;
                        fill_next = CW'(fill_reg - 1'b1);
                    end else begin
                        idx_next = CW'(idx_reg + 1'b1);
                    end
                end else begin
                    state_next = ST_RESULT;
                end
            end

            // First pass: how many future keys will be listed
            ST_COUNT: begin
                if (in_range && (cnt_reg != RW'(tieq_pkg::MAX_RESULTS))) begin
                    if (cur_f.future_key) begin
                        cnt_next = RW'(cnt_reg + 1'b1);
                    end
                    idx_next = CW'(idx_reg + 1'b1);
                end else begin
                    idx_next   = '0;
                    state_next = (cnt_reg == '0) ? ST_RESULT : ST_LIST;
                end
            end

            // Second pass: one beat per future key
            ST_LIST: begin
                if (!in_range) begin
                    state_next = ST_IDLE;
                end else if (cur_f.future_key) begin
                    if (out_free) begin
                        load      = 1'b1;
                        ld_hit    = 1'b1;
                        ld_ent    = cur;
                        ld_last   = (RW'(sent_reg + 1'b1) == cnt_reg);
                        sent_next = RW'(sent_reg + 1'b1);
                        idx_next  = CW'(idx_reg + 1'b1);
                        if (ld_last) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    idx_next = CW'(idx_reg + 1'b1);
                end
            end

            ST_RESULT: begin
                if (out_free) begin
                    load       = 1'b1;
                    ld_rej     = rej_reg;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            idx_reg     <= '0;
            fidx_reg    <= '0;
            found_reg   <= 1'b0;
            rej_reg     <= 1'b0;
            cnt_reg     <= '0;
            sent_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            fidx_reg    <= fidx_next;
            found_reg   <= found_next;
            rej_reg     <= rej_next;
            cnt_reg     <= cnt_next;
            sent_reg    <= sent_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            now_reg  <= s_now;
            new_reg  <= new_in;
        end
        if (load) begin
            out_hit_reg   <= ld_hit;
            out_rej_reg   <= ld_rej;
            out_last_reg  <= ld_last;
            out_ent_reg   <= ld_ent;
            out_count_reg <= 5'(fill_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = out_hit_reg;
    assign m_ev_kind     = out_ent_reg.kind;
    assign m_ev_time     = out_ent_reg.time_v;
    assign m_ev_key      = out_ent_reg.key;
    assign m_ev_down     = out_ent_reg.down;
    assign m_ev_h        = out_ent_reg.h;
    assign m_ev_v        = out_ent_reg.v;
    assign m_queue_count = out_count_reg;
    assign m_rejected    = out_rej_reg;
    assign m_last_item   = out_last_reg;

endmodule

`default_nettype wire

### tb/sv/tieq_result_check.sv
`timescale 1ns / 100ps

// Watches both channels of the event queue, keeps its own copy of the queue and
// compares every result beat against the oldest predicted beat.
module tieq_result_check #(
    parameter int QUEUE_DEPTH = tieq_pkg::DEFAULT_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [3:0]         s_mode,
    input  logic [31:0]        s_now,
    input  logic [31:0]        s_fire_time,
    input  logic [1:0]         s_kind,
    input  logic [7:0]         s_key,
    input  logic               s_down,
    input  logic signed [15:0] s_pos_h,
    input  logic signed [15:0] s_pos_v,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_hit,
    input  logic [1:0]         m_ev_kind,
    input  logic [31:0]        m_ev_time,
    input  logic [7:0]         m_ev_key,
    input  logic               m_ev_down,
    input  logic signed [15:0] m_ev_h,
    input  logic signed [15:0] m_ev_v,
    input  logic [4:0]         m_queue_count,
    input  logic               m_rejected,
    input  logic               m_last_item,
    output int                 mismatch_count,
    output int                 beats_owed
);
    import tieq_pkg::*;

    typedef struct packed {
        logic               hit;
        logic [1:0]         ev_kind;
        logic [31:0]        ev_time;
        logic [7:0]         ev_key;
        logic               ev_down;
        logic signed [15:0] ev_h;
        logic signed [15:0] ev_v;
        logic [4:0]         count;
        logic               rejected;
        logic               last_item;
    } beat_t;

    // Shadow copy of the queue
    entry_t slots [QUEUE_DEPTH];
    int     fill;

    beat_t expected_beats [$];
    beat_t want;

    initial begin
        mismatch_count = 0;
        beats_owed     = 0;
        fill           = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch(what, got, exp_val);
        end
    endtask

    // Append one predicted beat at the tail
    function automatic void add_expected(input beat_t b);
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    // Insert at the due/future position; 0 when the queue is full
    function automatic bit place_entry(input logic [31:0] now, input entry_t e);
        int slot_idx;
        int i;
        if (fill >= QUEUE_DEPTH) return 1'b0;
        if (e.time_v <= now) begin
            slot_idx = 0;
            while (slot_idx < fill && slots[slot_idx].time_v <= now) slot_idx++;
        end else begin
            slot_idx = fill;
            while (slot_idx > 0 && slots[slot_idx - 1].time_v > e.time_v) slot_idx--;
        end
        for (i = fill; i > slot_idx; i--) slots[i] = slots[i - 1];
        slots[slot_idx] = e;
        fill++;
        return 1'b1;
    endfunction

    // Last entry of a kind within the due prefix, or -1
    function automatic int last_due_of(input logic [31:0] now, input logic [1:0] kind);
        int found;
        int i;
        found = -1;
        for (i = 0; i < fill && slots[i].time_v <= now; i++) begin
            if (slots[i].kind == kind) found = i;
        end
        return found;
    endfunction

    function automatic beat_t make_beat(input int idx, input logic rej, input logic last);
        beat_t b;
        b = '0;
        if (idx >= 0) begin
            b.hit     = 1'b1;
            b.ev_kind = slots[idx].kind;
            b.ev_time = slots[idx].time_v;
            b.ev_key  = slots[idx].key;
            b.ev_down = slots[idx].down;
            b.ev_h    = slots[idx].h;
            b.ev_v    = slots[idx].v;
        end
        b.count     = 5'(fill);
        b.rejected  = rej;
        b.last_item = last;
        return b;
    endfunction

    function automatic bit is_future_key(input int i, input logic [31:0] now);
        return slots[i].time_v > now && slots[i].kind == KIND_KEY;
    endfunction

    // Apply one input beat to the shadow queue and queue up its result beats
    function automatic void predict_results(input logic [3:0] mode, input logic [31:0] now,
                                            input logic [31:0] ft, input logic [1:0] kind,
                                            input logic [7:0] key, input logic down,
                                            input logic signed [15:0] h,
                                            input logic signed [15:0] v);
        entry_t e;
        logic   rej;
        int     idx;
        int     i;
        int     w;
        int     n;
        int     total;
        rej = 1'b0;
        e   = '0;
        e.time_v = now;
        case (mode)
            MODE_PUSH: begin
                e.time_v = ft;
                e.kind   = kind;
                e.key    = key;
                e.down   = down;
                e.h      = h;
                e.v      = v;
                rej      = !place_entry(now, e);
            end
            MODE_KEY: begin
                e.kind = KIND_KEY;
                e.key  = key;
                e.down = down;
                rej    = !place_entry(now, e);
            end
            MODE_BUTTON: begin
                e.kind = KIND_BUTTON;
                e.down = down;
                rej    = !place_entry(now, e);
            end
            MODE_DELTA: begin
                idx = last_due_of(now, KIND_DELTA);
                if (idx >= 0) begin
                    // accumulate with 16-bit wrap
                    slots[idx].h = slots[idx].h + h;
                    slots[idx].v = slots[idx].v + v;
                end else begin
                    e.kind = KIND_DELTA;
                    e.h    = h;
                    e.v    = v;
                    rej    = !place_entry(now, e);
                end
            end
            MODE_POS: begin
                idx = last_due_of(now, KIND_POS);
                if (idx >= 0) begin
                    slots[idx].h = h;
                    slots[idx].v = v;
                end else begin
                    e.kind = KIND_POS;
                    e.h    = h;
                    e.v    = v;
                    rej    = !place_entry(now, e);
                end
            end
            MODE_PEEK: begin
                idx = (fill > 0 && slots[0].time_v <= now) ? 0 : -1;
                add_expected(make_beat(idx, 1'b0, 1'b1));
                return;
            end
            MODE_POP: begin
                if (fill > 0) begin
                    for (i = 1; i < fill; i++) slots[i - 1] = slots[i];
                    fill--;
                end
            end
            MODE_CLEAR: begin
                // drop future keys, keep the order of the rest
                w = 0;
                for (i = 0; i < fill; i++) begin
                    if (!is_future_key(i, now)) begin
                        slots[w] = slots[i];
                        w++;
                    end
                end
                fill = w;
            end
            MODE_LIST: begin
                total = 0;
                for (i = 0; i < fill && total < MAX_RESULTS; i++) begin
                    if (is_future_key(i, now)) total++;
                end
                n = 0;
                for (i = 0; i < fill && n < total; i++) begin
                    if (is_future_key(i, now)) begin
                        add_expected(make_beat(i, 1'b0, n == total - 1));
                        n++;
                    end
                end
                if (total == 0) add_expected(make_beat(-1, 1'b0, 1'b1));
                return;
            end
            default: begin
            end
        endcase
        add_expected(make_beat(-1, rej, 1'b1));
    endfunction

    // Compare outgoing beats first, then predict from the incoming beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            fill = 0;
            expected_beats.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("result beat with nothing expected",
                                    32'(m_queue_count), 32'd0);
                end else begin
                    want = expected_beats[0];
                    expected_beats.delete(0);
                    check_field("hit", 32'(m_hit), 32'(want.hit));
                    check_field("ev_kind", 32'(m_ev_kind), 32'(want.ev_kind));
                    check_field("ev_time", m_ev_time, want.ev_time);
                    check_field("ev_key", 32'(m_ev_key), 32'(want.ev_key));
                    check_field("ev_down", 32'(m_ev_down), 32'(want.ev_down));
                    check_field("ev_h", 32'($unsigned(m_ev_h)), 32'($unsigned(want.ev_h)));
                    check_field("ev_v", 32'($unsigned(m_ev_v)), 32'($unsigned(want.ev_v)));
                    check_field("queue_count", 32'(m_queue_count), 32'(want.count));
                    check_field("rejected", 32'(m_rejected), 32'(want.rejected));
                    check_field("last_item", 32'(m_last_item), 32'(want.last_item));
                end
            end
            if (s_valid && s_ready) begin
                predict_results(s_mode, s_now, s_fire_time, s_kind, s_key, s_down,
                                s_pos_h, s_pos_v);
            end
        end
        beats_owed = expected_beats.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tieq_pkg::*;

    localparam int         DEPTH           = DEFAULT_DEPTH;
    localparam int         QUIET_LIMIT     = 5000;
    localparam int         DRAIN_CYCLES    = 64;
    localparam logic [3:0] MODE_UNUSED_LOW = 4'd9;
    localparam logic [3:0] MODE_UNUSED_TOP = 4'd15;

    typedef struct {
        logic [3:0]         mode;
        logic [31:0]        now;
        logic [31:0]        fire_time;
        logic [1:0]         kind;
        logic [7:0]         key;
        logic               down;
        logic signed [15:0] h;
        logic signed [15:0] v;
    } item_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_mode      = '0;
    logic [31:0]        s_now       = '0;
    logic [31:0]        s_fire_time = '0;
    logic [1:0]         s_kind      = '0;
    logic [7:0]         s_key       = '0;
    logic               s_down      = 1'b0;
    logic signed [15:0] s_pos_h     = '0;
    logic signed [15:0] s_pos_v     = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_hit;
    logic [1:0]         m_ev_kind;
    logic [31:0]        m_ev_time;
    logic [7:0]         m_ev_key;
    logic               m_ev_down;
    logic signed [15:0] m_ev_h;
    logic signed [15:0] m_ev_v;
    logic [4:0]         m_queue_count;
    logic               m_rejected;
    logic               m_last_item;

    int          mismatch_count;
    int          beats_owed;
    int          send_idle_pct = 20;
    int          recv_idle_pct = 75;
    int          items_sent    = 0;
    int          quiet_cycles  = 0;
    logic [31:0] cur_now       = 32'd0;

    always #5 aclk = ~aclk;

    timed_input_event_queue #(.QUEUE_DEPTH(DEPTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_now(s_now),
        .s_fire_time(s_fire_time), .s_kind(s_kind), .s_key(s_key), .s_down(s_down),
        .s_pos_h(s_pos_h), .s_pos_v(s_pos_v),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit), .m_ev_kind(m_ev_kind),
        .m_ev_time(m_ev_time), .m_ev_key(m_ev_key), .m_ev_down(m_ev_down),
        .m_ev_h(m_ev_h), .m_ev_v(m_ev_v), .m_queue_count(m_queue_count),
        .m_rejected(m_rejected), .m_last_item(m_last_item)
    );

    tieq_result_check #(.QUEUE_DEPTH(DEPTH)) u_result_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_now(s_now),
        .s_fire_time(s_fire_time), .s_kind(s_kind), .s_key(s_key), .s_down(s_down),
        .s_pos_h(s_pos_h), .s_pos_v(s_pos_v),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit), .m_ev_kind(m_ev_kind),
        .m_ev_time(m_ev_time), .m_ev_key(m_ev_key), .m_ev_down(m_ev_down),
        .m_ev_h(m_ev_h), .m_ev_v(m_ev_v), .m_queue_count(m_queue_count),
        .m_rejected(m_rejected), .m_last_item(m_last_item),
        .mismatch_count(mismatch_count), .beats_owed(beats_owed)
    );

    // Result side back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: too long without any beat on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic item_t make_item(input logic [3:0] mode, input logic [31:0] now,
                                        input logic [31:0] ft, input logic [1:0] kind,
                                        input logic [7:0] key, input logic down,
                                        input logic signed [15:0] h,
                                        input logic signed [15:0] v);
        item_t it;
        it.mode      = mode;
        it.now       = now;
        it.fire_time = ft;
        it.kind      = kind;
        it.key       = key;
        it.down      = down;
        it.h         = h;
        it.v         = v;
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_item(input item_t it);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= it.mode;
        s_now       <= it.now;
        s_fire_time <= it.fire_time;
        s_kind      <= it.kind;
        s_key       <= it.key;
        s_down      <= it.down;
        s_pos_h     <= it.h;
        s_pos_v     <= it.v;
        taken = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            taken = s_ready;
        end
        items_sent++;
        @(negedge aclk);
    endtask

    // Emulated time mostly creeps forward, with the odd jump anywhere
    task automatic step_clock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            cur_now = $urandom;
        end else if (r < 6) begin
            cur_now = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFF0;
        end else begin
            cur_now = cur_now + $urandom_range(0, 12);
        end
    endtask

    function automatic logic [31:0] pick_fire_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return cur_now + $urandom_range(1, 80);
        if (r < 80) return cur_now - $urandom_range(0, 40);
        if (r < 90) return $urandom;
        if (r < 95) return 32'd0;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic item_t rand_item();
        return make_item(4'($urandom_range(0, 15)), cur_now, pick_fire_time(),
                         2'($urandom), 8'($urandom), 1'($urandom),
                         16'($urandom), 16'($urandom));
    endfunction

    // One loose item; draining leans on pops so the queue empties again
    task automatic send_random(input bit draining);
        item_t it;
        int    r;
        step_clock();
        it = rand_item();
        r  = $urandom_range(0, 99);
        if (draining) begin
            if (r < 45)      it.mode = MODE_POP;
            else if (r < 55) it.mode = MODE_PEEK;
            else if (r < 62) it.mode = MODE_CLEAR;
            else if (r < 70) it.mode = MODE_LIST;
            else if (r < 75) it.mode = 4'($urandom_range(MODE_UNUSED_LOW, MODE_UNUSED_TOP));
            else             it.mode = 4'($urandom_range(MODE_PUSH, MODE_POS));
        end else begin
            if (r < 25)      it.mode = MODE_PUSH;
            else if (r < 38) it.mode = MODE_KEY;
            else if (r < 48) it.mode = MODE_BUTTON;
            else if (r < 60) it.mode = MODE_DELTA;
            else if (r < 70) it.mode = MODE_POS;
            else if (r < 78) it.mode = MODE_PEEK;
            else if (r < 88) it.mode = MODE_POP;
            else if (r < 92) it.mode = MODE_CLEAR;
            else if (r < 97) it.mode = MODE_LIST;
            else             it.mode = 4'($urandom_range(MODE_UNUSED_LOW, MODE_UNUSED_TOP));
        end
        send_item(it);
    endtask

    // Empty the queue, then flood it with future keys past full
    task automatic play_flood();
        item_t it;
        step_clock();
        repeat (DEPTH) send_item(make_item(MODE_POP, cur_now, 0, KIND_KEY, 0, 0, 0, 0));
        if ($urandom_range(0, 1)) begin
            it = rand_item();
            it.mode = MODE_DELTA;
            send_item(it);
        end
        repeat (DEPTH + 2) begin
            it = rand_item();
            it.mode      = MODE_PUSH;
            it.kind      = KIND_KEY;
            it.fire_time = cur_now + $urandom_range(1, 400);
            send_item(it);
        end
        // queue full: merging pushes may still land, new slots may not
        it = rand_item();
        it.mode = MODE_DELTA;
        send_item(it);
        it = rand_item();
        it.mode = MODE_POS;
        send_item(it);
        send_item(make_item(MODE_LIST, cur_now, 0, KIND_KEY, 0, 0, 0, 0));
        send_item(make_item(MODE_CLEAR, cur_now, 0, KIND_KEY, 0, 0, 0, 0));
    endtask

    // A press, some mouse motion, a scheduled release, then the consumer catches up
    task automatic play_typing();
        item_t       it;
        logic [7:0]  code;
        int          n;
        step_clock();
        code = $urandom;
        it = rand_item();
        it.mode = MODE_KEY;
        it.key  = code;
        it.down = 1'b1;
        send_item(it);
        n = $urandom_range(1, 4);
        repeat (n) begin
            it = rand_item();
            it.mode = $urandom_range(0, 3) == 0 ? MODE_POS : MODE_DELTA;
            if ($urandom_range(0, 1)) begin
                it.h = 16'($signed($urandom_range(0, 20)) - 10);
                it.v = 16'($signed($urandom_range(0, 20)) - 10);
            end
            send_item(it);
        end
        if ($urandom_range(0, 2) == 0) begin
            it = rand_item();
            it.mode = MODE_BUTTON;
            send_item(it);
        end
        it = rand_item();
        it.mode      = MODE_PUSH;
        it.kind      = KIND_KEY;
        it.key       = code;
        it.down      = 1'b0;
        it.fire_time = cur_now + $urandom_range(1, 30);
        send_item(it);
        send_item(make_item(MODE_LIST, cur_now, 0, KIND_KEY, 0, 0, 0, 0));
        if ($urandom_range(0, 4) == 0) begin
            send_item(make_item(MODE_CLEAR, cur_now, 0, KIND_KEY, 0, 0, 0, 0));
        end
        cur_now = cur_now + $urandom_range(0, 40);
        n = $urandom_range(1, 5);
        repeat (n) begin
            send_item(make_item(MODE_PEEK, cur_now, 0, KIND_KEY, 0, 0, 0, 0));
            send_item(make_item(MODE_POP, cur_now, 0, KIND_KEY, 0, 0, 0, 0));
        end
    endtask

    // Stimulus
    initial begin
        int  phase;
        int  target [3];
        bit  draining;
        target   = '{170, 320, 470};
        draining = 1'b0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty queue corners
        send_item(make_item(MODE_PEEK, 0, 0, KIND_KEY, 0, 0, 0, 0));
        send_item(make_item(MODE_LIST, 0, 0, KIND_KEY, 0, 0, 0, 0));
        send_item(make_item(MODE_CLEAR, 0, 0, KIND_KEY, 0, 0, 0, 0));
        send_item(make_item(MODE_POP, 0, 0, KIND_KEY, 0, 0, 0, 0));
        send_item(make_item(MODE_UNUSED_TOP, 0, 0, KIND_KEY, 0, 0, 0, 0));
        // Delta merge with wrap, position overwrite
        send_item(make_item(MODE_DELTA, 100, 0, KIND_KEY, 0, 0, 16'sh7FFF, 16'sh8000));
        send_item(make_item(MODE_DELTA, 100, 0, KIND_KEY, 0, 0, 16'sd1, -16'sd1));
        send_item(make_item(MODE_POS, 100, 0, KIND_KEY, 0, 0, 16'sh8000, 16'sh7FFF));
        send_item(make_item(MODE_POS, 100, 0, KIND_KEY, 0, 0, 16'sd7, -16'sd7));
        send_item(make_item(MODE_KEY, 100, 0, KIND_KEY, 8'hFF, 1'b1, 0, 0));
        send_item(make_item(MODE_BUTTON, 100, 0, KIND_KEY, 0, 1'b1, 0, 0));
        // Future entries: latest time, equal times kept in order, non-key
        send_item(make_item(MODE_PUSH, 100, 32'hFFFF_FFFF, KIND_KEY, 8'h00, 0, 0, 0));
        send_item(make_item(MODE_PUSH, 100, 500, KIND_KEY, 8'h01, 1, 0, 0));
        send_item(make_item(MODE_PUSH, 100, 500, KIND_KEY, 8'h02, 0, 0, 0));
        send_item(make_item(MODE_PUSH, 100, 300, KIND_BUTTON, 8'h03, 1, 0, 0));
        // Past time: joins the back of the due part
        send_item(make_item(MODE_PUSH, 100, 0, KIND_POS, 8'h04, 1, 16'sd3, -16'sd3));
        send_item(make_item(MODE_PEEK, 100, 0, KIND_KEY, 0, 0, 0, 0));
        send_item(make_item(MODE_LIST, 100, 0, KIND_KEY, 0, 0, 0, 0));
        send_item(make_item(MODE_CLEAR, 100, 0, KIND_KEY, 0, 0, 0, 0));
        send_item(make_item(MODE_LIST, 100, 0, KIND_KEY, 0, 0, 0, 0));
        send_item(make_item(MODE_POP, 100, 0, KIND_KEY, 0, 0, 0, 0));
        // Front not yet due
        send_item(make_item(MODE_PEEK, 0, 0, KIND_KEY, 0, 0, 0, 0));
        send_item(make_item(MODE_UNUSED_LOW, 0, 0, KIND_KEY, 0, 0, 0, 0));
        cur_now = 32'd200;

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            play_flood();
            while (items_sent < target[phase]) begin
                if ($urandom_range(0, 99) < 50) begin
                    play_typing();
                end else begin
                    if ($urandom_range(0, 3) == 0) draining = !draining;
                    repeat ($urandom_range(4, 16)) send_random(draining);
                end
            end
            // hold off until every result of this phase is in
            s_valid <= 1'b0;
            while (beats_owed != 0) @(negedge aclk);
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && beats_owed == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
